/* src/assert_macros.svh */
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* src/sess_pkg.sv */
package sess_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W = 16;
    localparam int KEY_W = 64;
    localparam int SLOT_W = 4;
    localparam int COUNT_OUT_W = 5;

    localparam int ALLOC_FIRST = 1;
    localparam int ALLOC_LAST = 255;
    // with at most TABLE_DEPTH ids in use, the answer never lies above TABLE_DEPTH + 1
    localparam int ALLOC_SPAN = (TABLE_DEPTH + 1 < ALLOC_LAST) ? TABLE_DEPTH + 1 : ALLOC_LAST;
    localparam int MAP_IDX_W = $clog2(ALLOC_SPAN);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_ALLOC  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NO_ID     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic req_load;
        logic ptr_clr;
        logic ptr_inc;
        logic mem_rd;
        logic shift_wr;
        logic add_wr;
        logic count_dec;
        logic map_clr;
        logic map_mark;
        logic res_found;
        logic res_miss;
        logic res_full;
        logic res_removed;
        logic res_alloc;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       cnt_zero;
        logic       full;
        logic       match;
        logic       ptr_last;
    } sts_t;

endpackage

/* src/session_table_with_id_allocator.sv */
// one request at a time: an add writes the table straight away; a lookup reads and checks
// the entries in order until a hit or the last entry; a remove does the same and then shifts
// each later entry one place down; an alloc reads every entry and then picks an id; the pace
// is set by the one-port table memory with a registered read
// throughput: next request accepted in the cycle after the result is registered
// rst_n asynchronous active low: table empty, no result pending
module session_table_with_id_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       op,
    input  logic [sess_pkg::ID_W-1:0]        node_id,
    input  logic [sess_pkg::KEY_W-1:0]       key_high,
    input  logic [sess_pkg::KEY_W-1:0]       key_low,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic [sess_pkg::SLOT_W-1:0]      slot,
    output logic [sess_pkg::ID_W-1:0]        id_out,
    output logic [sess_pkg::KEY_W-1:0]       key_high_out,
    output logic [sess_pkg::KEY_W-1:0]       key_low_out,
    output logic [sess_pkg::COUNT_OUT_W-1:0] entry_count
);
    import sess_pkg::*;

    `include "assert_macros.svh"

    cmd_t cmd;
    sts_t sts;

    sess_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sess_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .node_id      (node_id),
        .key_high     (key_high),
        .key_low      (key_low),
        .status       (status),
        .slot         (slot),
        .id_out       (id_out),
        .key_high_out (key_high_out),
        .key_low_out  (key_low_out),
        .entry_count  (entry_count)
    );

    `ASSERT_PROP(a_busy_after_accept, clk, rst_n,
        (req_valid && !req_stall) |=> req_stall,
        "accepted transaction did not make the block busy")
    `ASSERT_NEVER(a_count_range, clk, rst_n,
        rsp_valid && (entry_count > COUNT_OUT_W'(TABLE_DEPTH)),
        "entry count above table depth")
    `ASSERT_PROP(a_full_count, clk, rst_n,
        (rsp_valid && status == ST_FULL) |-> (entry_count == COUNT_OUT_W'(TABLE_DEPTH)),
        "full reported on a table with room")
    `ASSERT_PROP(a_miss_clean, clk, rst_n,
        (rsp_valid && status == ST_NOT_FOUND) |->
            (key_high_out == '0 && key_low_out == '0 && id_out == '0),
        "miss result carries entry data")
    `ASSERT_NEVER(a_load_in_flight, clk, rst_n,
        cmd.out_load && cmd.req_load,
        "result loaded while accepting a transaction")

endmodule

/* src/sess_ctrl.sv */
module sess_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  sess_pkg::sts_t sts,
    output sess_pkg::cmd_t cmd
);
    import sess_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_READ     = 3'd2;
    localparam logic [2:0] S_CHECK    = 3'd3;
    localparam logic [2:0] S_PICK     = 3'd4;
    localparam logic [2:0] S_SHIFT_RD = 3'd5;
    localparam logic [2:0] S_SHIFT_WR = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.ptr_clr = 1'b1;
                case (sts.op)
                    OP_ADD:
                    begin
                        if (sts.full)
                            cmd.res_full = 1'b1;
                        else
                            cmd.add_wr = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_ALLOC:
                    begin
                        cmd.map_clr = 1'b1;
                        state_next = sts.cnt_zero ? S_PICK : S_READ;
                    end
                    default:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.res_miss = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_READ;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                case (sts.op)
                    OP_LOOKUP:
                    begin
                        if (sts.match)
                        begin
                            cmd.res_found = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (sts.ptr_last)
                        begin
                            cmd.res_miss = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_inc = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (sts.match)
                        begin
                            cmd.res_removed = 1'b1;
                            if (sts.ptr_last)
                            begin
                                cmd.count_dec = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd.ptr_inc = 1'b1;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        else if (sts.ptr_last)
                        begin
                            cmd.res_miss = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_inc = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    OP_ALLOC:
                    begin
                        cmd.map_mark = 1'b1;
                        if (sts.ptr_last)
                            state_next = S_PICK;
                        else
                        begin
                            cmd.ptr_inc = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PICK:
            begin
                cmd.res_alloc = 1'b1;
                state_next = S_DONE;
            end
            S_SHIFT_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // ptr is the source entry, written one place down
                cmd.shift_wr = 1'b1;
                if (sts.ptr_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next = S_SHIFT_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/sess_dp.sv */
module sess_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sess_pkg::cmd_t              cmd,
    output sess_pkg::sts_t              sts,
    input  logic [1:0]                  op,
    input  logic [sess_pkg::ID_W-1:0]   node_id,
    input  logic [sess_pkg::KEY_W-1:0]  key_high,
    input  logic [sess_pkg::KEY_W-1:0]  key_low,
    output logic [1:0]                  status,
    output logic [sess_pkg::SLOT_W-1:0] slot,
    output logic [sess_pkg::ID_W-1:0]   id_out,
    output logic [sess_pkg::KEY_W-1:0]  key_high_out,
    output logic [sess_pkg::KEY_W-1:0]  key_low_out,
    output logic [sess_pkg::COUNT_OUT_W-1:0] entry_count
);
    import sess_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic [1:0]       op_reg;
    entry_t           req_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [ALLOC_SPAN-1:0] map_reg;

    logic [1:0]        res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [KEY_W-1:0]  res_kh_reg;
    logic [KEY_W-1:0]  res_kl_reg;

    logic [1:0]        out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [KEY_W-1:0]  out_kh_reg;
    logic [KEY_W-1:0]  out_kl_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic            mark_hit;
    logic [MAP_IDX_W-1:0] mark_idx;
    logic            pick_found;
    logic [ID_W-1:0] pick_id;

    assign sts.op       = op_reg;
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.full     = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign sts.match    = (rd_data_reg.id == req_reg.id);
    assign sts.ptr_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) >= count_reg);

    // table storage, one read or one write a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
            mem[count_reg[IDX_W-1:0]] <= req_reg;
        else if (cmd.shift_wr)
            mem[ptr_reg - IDX_W'(1)] <= rd_data_reg;
        if (cmd.mem_rd)
            rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            op_reg <= op;
            req_reg.id <= node_id;
            req_reg.key_high <= key_high;
            req_reg.key_low <= key_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.ptr_clr)
                ptr_reg <= '0;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + IDX_W'(1);
            if (cmd.add_wr)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.count_dec)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // only ids 1..ALLOC_SPAN can change the allocation result
    assign mark_hit = (rd_data_reg.id >= ID_W'(ALLOC_FIRST)) &&
                      (rd_data_reg.id <= ID_W'(ALLOC_SPAN));
    assign mark_idx = MAP_IDX_W'(rd_data_reg.id - ID_W'(ALLOC_FIRST));

    always_ff @(posedge clk)
    begin
        if (cmd.map_clr)
            map_reg <= '0;
        else if (cmd.map_mark && mark_hit)
            map_reg[mark_idx] <= 1'b1;
    end

    always_comb
    begin
        pick_found = 1'b0;
        pick_id = '0;
        for (int i = ALLOC_SPAN - 1; i >= 0; i--)
        begin
            if (!map_reg[i])
            begin
                pick_found = 1'b1;
                pick_id = ID_W'(i + ALLOC_FIRST);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_found)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg <= SLOT_W'(ptr_reg);
            res_id_reg <= rd_data_reg.id;
            res_kh_reg <= rd_data_reg.key_high;
            res_kl_reg <= rd_data_reg.key_low;
        end
        else if (cmd.res_removed)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg <= SLOT_W'(ptr_reg);
            res_id_reg <= req_reg.id;
            res_kh_reg <= '0;
            res_kl_reg <= '0;
        end
        else if (cmd.add_wr)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg <= SLOT_W'(count_reg);
            res_id_reg <= req_reg.id;
            res_kh_reg <= '0;
            res_kl_reg <= '0;
        end
        else if (cmd.res_alloc)
        begin
            res_status_reg <= pick_found ? ST_OK : ST_NO_ID;
            res_slot_reg <= '0;
            res_id_reg <= pick_id;
            res_kh_reg <= '0;
            res_kl_reg <= '0;
        end
        else if (cmd.res_miss || cmd.res_full)
        begin
            res_status_reg <= cmd.res_full ? ST_FULL : ST_NOT_FOUND;
            res_slot_reg <= '0;
            res_id_reg <= '0;
            res_kh_reg <= '0;
            res_kl_reg <= '0;
        end
    end

    // output register holds the finished transaction while the next one is accepted
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg <= res_slot_reg;
            out_id_reg <= res_id_reg;
            out_kh_reg <= res_kh_reg;
            out_kl_reg <= res_kl_reg;
            out_count_reg <= COUNT_OUT_W'(count_reg);
        end
    end

    assign status = out_status_reg;
    assign slot = out_slot_reg;
    assign id_out = out_id_reg;
    assign key_high_out = out_kh_reg;
    assign key_low_out = out_kl_reg;
    assign entry_count = out_count_reg;

endmodule
